// ===== hdl/gffr_pkg.sv =====
// ----------------------------------------------------------------------------
// gffr_pkg: shared types and constants for the grid flood-fill block
// Cell kinds, register indexes, fill directions and the config/stack records.
// ----------------------------------------------------------------------------
package gffr_pkg;

  localparam int CFG_IW  = 3;   // config register index width
  localparam int CFG_DW  = 13;  // config write data width
  localparam int DIM_W   = 7;   // row / column / dimension width
  localparam int POS_W   = 6;   // start position width
  localparam int CNT_W   = 13;  // collectible counter width
  localparam int GADDR_W = 14;  // linear grid address width (127 * 127 fits)

  localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;

  typedef enum logic [1:0] {
    KIND_OPEN = 2'd0,
    KIND_WALL = 2'd1,
    KIND_COLL = 2'd2,
    KIND_EXIT = 2'd3
  } kind_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_GRID_WIDTH  = 3'd0,
    REG_GRID_HEIGHT = 3'd1,
    REG_START_COL   = 3'd2,
    REG_START_ROW   = 3'd3,
    REG_EXPECTED    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    DIR_SELF  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_UP    = 3'd3,
    DIR_DOWN  = 3'd4
  } dir_t;

  // Effective configuration seen by the fill engine
  typedef struct packed {
    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [POS_W-1:0] start_col;
    logic [POS_W-1:0] start_row;
    logic [CNT_W-1:0] expected;
  } gffr_cfg_t;

  // One pending cell: position plus its linear address
  typedef struct packed {
    logic [DIM_W-1:0]   row;
    logic [DIM_W-1:0]   col;
    logic [GADDR_W-1:0] addr;
  } stk_ent_t;

endpackage

// ===== hdl/gffr_in_if.sv =====
// ----------------------------------------------------------------------------
// gffr_in_if: map cell input channel
// One cell per transaction, last_cell marks the end of the map.
// ----------------------------------------------------------------------------
interface gffr_in_if import gffr_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] cell_kind;
  logic       last_cell;

  modport source (output valid, output cell_kind, output last_cell, input ready);
  modport sink   (input valid, input cell_kind, input last_cell, output ready);
endinterface

// ===== hdl/gffr_out_if.sv =====
// ----------------------------------------------------------------------------
// gffr_out_if: reachability result channel
// One transaction per loaded map.
// ----------------------------------------------------------------------------
interface gffr_out_if import gffr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             path_ok;
  logic [CNT_W-1:0] collectibles_reached;
  logic             exit_reached;

  modport source (output valid, output path_ok, output collectibles_reached,
                  output exit_reached, input ready);
  modport sink   (input valid, input path_ok, input collectibles_reached,
                  input exit_reached, output ready);
endinterface

// ===== hdl/gffr_cfg_if.sv =====
// ----------------------------------------------------------------------------
// gffr_cfg_if: configuration write channel
// Register index and write data, one register per transaction.
// ----------------------------------------------------------------------------
interface gffr_cfg_if import gffr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/gffr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// gffr_cfg_regs: configuration register file
// Holds the five registers and clamps the map size to the built capacity.
// ----------------------------------------------------------------------------
module gffr_cfg_regs import gffr_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  gffr_cfg_if.sink   cfg_chan,
  output gffr_cfg_t  cfg_o
);

  localparam int CMP_W = 10;  // holds 7-bit values and limits up to 1023

  logic [DIM_W-1:0] grid_width_r, grid_width_nxt;
  logic [DIM_W-1:0] grid_height_r, grid_height_nxt;
  logic [POS_W-1:0] start_col_r, start_col_nxt;
  logic [POS_W-1:0] start_row_r, start_row_nxt;
  logic [CNT_W-1:0] expected_r, expected_nxt;

  assign cfg_chan.ready = 1'b1;

  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    start_col_nxt   = start_col_r;
    start_row_nxt   = start_row_r;
    expected_nxt    = expected_r;
    if (cfg_chan.valid) begin
      case (cfg_reg_t'(cfg_chan.index))
        REG_GRID_WIDTH:  grid_width_nxt  = cfg_chan.data[DIM_W-1:0];
        REG_GRID_HEIGHT: grid_height_nxt = cfg_chan.data[DIM_W-1:0];
        REG_START_COL:   start_col_nxt   = cfg_chan.data[POS_W-1:0];
        REG_START_ROW:   start_row_nxt   = cfg_chan.data[POS_W-1:0];
        REG_EXPECTED:    expected_nxt    = cfg_chan.data[CNT_W-1:0];
        default: ;  // unmapped index, write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= DIM_W'(1);
      grid_height_r <= DIM_W'(1);
      start_col_r   <= '0;
      start_row_r   <= '0;
      expected_r    <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      start_col_r   <= start_col_nxt;
      start_row_r   <= start_row_nxt;
      expected_r    <= expected_nxt;
    end
  end

  // Clamp to capacity; the limit is only taken when it is below the 7-bit value
  always_comb begin
    cfg_o.eff_w = (CMP_W'(grid_width_r) > CMP_W'(MAX_WIDTH))
                  ? DIM_W'(MAX_WIDTH) : grid_width_r;
    cfg_o.eff_h = (CMP_W'(grid_height_r) > CMP_W'(MAX_HEIGHT))
                  ? DIM_W'(MAX_HEIGHT) : grid_height_r;
    cfg_o.start_col = start_col_r;
    cfg_o.start_row = start_row_r;
    cfg_o.expected  = expected_r;
  end

endmodule

// ===== hdl/grid_flood_fill_reachability.sv =====
// ----------------------------------------------------------------------------
// grid_flood_fill_reachability: 4-connected flood-fill reachability checker
// Loads a grid map, floods it from a start cell and reports collectibles/exit.
// ----------------------------------------------------------------------------
// Map cells arrive one per transaction in row-major order and are written to
// the cell memory at one cell per clock. The transaction with last_cell set
// starts the fill; the input stalls until the fill finishes, and the result is
// then parked in an output register so the next map can load while it waits.
// The fill is a depth-first walk with an explicit stack memory. Each tried
// neighbor is bounds-checked first; one that is out of bounds or not loaded
// is skipped, otherwise the cell memory is read and the cell is then marked
// and pushed. Each popped cell takes a stack read before its neighbors are
// tried. When the stack is empty, the block waits until any parked result
// has drained before handing over the new one. Visited cells are
// marked by rewriting them as walls, and cells at or above the load count read
// as walls, so no clearing pass is needed between maps or after reset.
// ----------------------------------------------------------------------------
module grid_flood_fill_reachability import gffr_pkg::*; #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  gffr_in_if.sink     in_chan,
  gffr_out_if.source  out_chan,
  gffr_cfg_if.sink    cfg_chan
);

  localparam int CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int LW  = (AW + 1 > GADDR_W) ? AW + 1 : GADDR_W;
  localparam logic [AW:0] CAP_CNT = (AW + 1)'(CAP);

  typedef enum logic [6:0] {
    S_LOAD  = 7'b0000001,  // taking map cells
    S_START = 7'b0000010,  // form start cell address
    S_TRY   = 7'b0000100,  // bounds check, issue cell read
    S_CHECK = 7'b0001000,  // inspect cell, mark and push
    S_POP   = 7'b0010000,  // issue stack read
    S_POPW  = 7'b0100000,  // stack data back, new base cell
    S_DONE  = 7'b1000000   // hand result to output register
  } state_t;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  gffr_cfg_t cfg;

  gffr_cfg_regs #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_chan (cfg_chan),
    .cfg_o    (cfg)
  );

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  state_t           state_r, state_nxt;
  logic [AW:0]      load_cnt_r, load_cnt_nxt;   // cells loaded, also wall fence
  logic [AW:0]      stk_top_r, stk_top_nxt;
  logic [CNT_W-1:0] found_r, found_nxt;
  logic             exit_r, exit_nxt;
  stk_ent_t         base_r, base_nxt;           // cell whose neighbors are tried
  stk_ent_t         try_r, try_nxt;             // neighbor under inspection
  dir_t             dir_r, dir_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [CNT_W-1:0] out_cnt_r, out_cnt_nxt;
  logic             out_exit_r, out_exit_nxt;

  // --------------------------------------------------------------------------
  // Memories: cell kinds and the pending-cell stack
  // --------------------------------------------------------------------------
  logic [1:0]    cell_mem [CAP];
  logic          cell_we, cell_re;
  logic [AW-1:0] cell_waddr, cell_raddr;
  logic [1:0]    cell_wdata, cell_rdata_r;

  stk_ent_t      stk_mem [CAP];
  logic          stk_we, stk_re;
  logic [AW-1:0] stk_waddr, stk_raddr;
  stk_ent_t      stk_wdata, stk_rdata_r;

  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (cell_re) begin
      cell_rdata_r <= cell_mem[cell_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    if (stk_re) begin
      stk_rdata_r <= stk_mem[stk_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Neighbor generation: addresses move by +-1 or +-width, no multiply
  // --------------------------------------------------------------------------
  stk_ent_t    nb;
  logic        nb_ok;
  logic        nb_in;
  logic [LW-1:0] nb_addr_l;
  logic [AW:0] stk_dec;
  logic        last_dir;
  dir_t        dir_succ;
  logic        in_acc;
  logic [LW-1:0] try_addr_l;
  logic [AW-1:0] try_addr_idx;

  always_comb begin
    nb    = base_r;
    nb_ok = 1'b1;
    case (dir_r)
      DIR_SELF: ;  // the start cell itself
      DIR_RIGHT: begin
        nb.col  = base_r.col + DIM_W'(1);
        nb.addr = base_r.addr + GADDR_W'(1);
      end
      DIR_LEFT: begin
        nb_ok   = (base_r.col != '0);
        nb.col  = base_r.col - DIM_W'(1);
        nb.addr = base_r.addr - GADDR_W'(1);
      end
      DIR_UP: begin
        nb_ok   = (base_r.row != '0);
        nb.row  = base_r.row - DIM_W'(1);
        nb.addr = base_r.addr - GADDR_W'(cfg.eff_w);
      end
      DIR_DOWN: begin
        nb.row  = base_r.row + DIM_W'(1);
        nb.addr = base_r.addr + GADDR_W'(cfg.eff_w);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  // Unloaded cells are walls; load count never exceeds capacity
  assign nb_addr_l = LW'(nb.addr);
  assign nb_in     = nb_ok && (nb.row < cfg.eff_h) && (nb.col < cfg.eff_w) &&
                     (nb_addr_l < LW'(load_cnt_r));

  assign try_addr_l   = LW'(try_r.addr);
  assign try_addr_idx = try_addr_l[AW-1:0];

  assign last_dir = (dir_r == DIR_SELF) || (dir_r == DIR_DOWN);

  always_comb begin
    case (dir_r)
      DIR_RIGHT: dir_succ = DIR_LEFT;
      DIR_LEFT:  dir_succ = DIR_UP;
      DIR_UP:    dir_succ = DIR_DOWN;
      default:   dir_succ = DIR_RIGHT;
    endcase
  end

  assign stk_dec = stk_top_r - (AW + 1)'(1);
  assign in_acc  = in_chan.valid && in_chan.ready;

  // --------------------------------------------------------------------------
  // Control
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt    = state_r;
    load_cnt_nxt = load_cnt_r;
    stk_top_nxt  = stk_top_r;
    found_nxt    = found_r;
    exit_nxt     = exit_r;
    base_nxt     = base_r;
    try_nxt      = try_r;
    dir_nxt      = dir_r;

    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_cnt_nxt   = out_cnt_r;
    out_exit_nxt  = out_exit_r;

    in_chan.ready = 1'b0;

    cell_we    = 1'b0;
    cell_waddr = load_cnt_r[AW-1:0];
    cell_wdata = in_chan.cell_kind;
    cell_re    = 1'b0;
    cell_raddr = nb_addr_l[AW-1:0];

    stk_we    = 1'b0;
    stk_waddr = stk_top_r[AW-1:0];
    stk_wdata = try_r;
    stk_re    = 1'b0;
    stk_raddr = stk_dec[AW-1:0];

    // result taken downstream
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_LOAD: begin
        in_chan.ready = 1'b1;
        if (in_acc) begin
          // cells beyond capacity are dropped
          if (load_cnt_r < CAP_CNT) begin
            cell_we      = 1'b1;
            load_cnt_nxt = load_cnt_r + (AW + 1)'(1);
          end
          if (in_chan.last_cell) begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        base_nxt.row  = DIM_W'(cfg.start_row);
        base_nxt.col  = DIM_W'(cfg.start_col);
        base_nxt.addr = GADDR_W'(cfg.start_row) * GADDR_W'(cfg.eff_w) +
                        GADDR_W'(cfg.start_col);
        dir_nxt       = DIR_SELF;
        stk_top_nxt   = '0;
        found_nxt     = '0;
        exit_nxt      = 1'b0;
        state_nxt     = S_TRY;
      end

      S_TRY: begin
        if (nb_in) begin
          cell_re   = 1'b1;
          try_nxt   = nb;
          state_nxt = S_CHECK;
        end else if (last_dir) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt = dir_succ;
        end
      end

      S_CHECK: begin
        // walls include already visited cells
        if (cell_rdata_r != KIND_WALL) begin
          cell_we    = 1'b1;
          cell_waddr = try_addr_idx;
          cell_wdata = KIND_WALL;
          if (cell_rdata_r == KIND_EXIT) begin
            exit_nxt = 1'b1;  // exits are not expanded
          end else begin
            if ((cell_rdata_r == KIND_COLL) && (found_r != COUNT_MAX)) begin
              found_nxt = found_r + CNT_W'(1);
            end
            if (stk_top_r < CAP_CNT) begin
              stk_we      = 1'b1;
              stk_top_nxt = stk_top_r + (AW + 1)'(1);
            end
          end
        end
        if (last_dir) begin
          state_nxt = S_POP;
        end else begin
          dir_nxt   = dir_succ;
          state_nxt = S_TRY;
        end
      end

      S_POP: begin
        if (stk_top_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          stk_re      = 1'b1;
          stk_top_nxt = stk_dec;
          state_nxt   = S_POPW;
        end
      end

      S_POPW: begin
        base_nxt  = stk_rdata_r;
        dir_nxt   = DIR_RIGHT;
        state_nxt = S_TRY;
      end

      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = exit_r && (found_r == cfg.expected);
          out_cnt_nxt   = found_r;
          out_exit_nxt  = exit_r;
          // new map starts empty: everything past the load count is a wall
          load_cnt_nxt  = '0;
          found_nxt     = '0;
          exit_nxt      = 1'b0;
          state_nxt     = S_LOAD;
        end
      end

      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      load_cnt_r  <= '0;
      stk_top_r   <= '0;
      found_r     <= '0;
      exit_r      <= 1'b0;
      dir_r       <= DIR_SELF;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      stk_top_r   <= stk_top_nxt;
      found_r     <= found_nxt;
      exit_r      <= exit_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    try_r      <= try_nxt;
    out_ok_r   <= out_ok_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_exit_r <= out_exit_nxt;
  end

  assign out_chan.valid                = out_valid_r;
  assign out_chan.path_ok              = out_ok_r;
  assign out_chan.collectibles_reached = out_cnt_r;
  assign out_chan.exit_reached         = out_exit_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_counts_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (stk_top_r <= CAP_CNT) && (load_cnt_r <= CAP_CNT))
    else $error("stack or load count beyond capacity");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the done state");

  a_check_after_try: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> $past(state_r == S_TRY))
    else $error("cell check without a preceding read");

  a_stack_empty_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (stk_top_r == '0))
    else $error("fill finished with pending cells");

endmodule
